// ----- sv/sjf_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and control structs for the SJF waiting/turnaround calculator.
package sjf_pkg;

   localparam int MAX_JOBS      = 16;
   localparam int BURST_BITS    = 16;
   localparam int IN_BURST_BITS = 16;
   localparam int POS_BITS      = 4;
   localparam int SUM_BITS      = 20;
   localparam int IDX_BITS      = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int CNT_BITS      = $clog2(MAX_JOBS + 1);
   localparam int ADD_BITS      = ((SUM_BITS > BURST_BITS) ? SUM_BITS : BURST_BITS) + 1;

   typedef logic [BURST_BITS-1:0] burst_type;
   typedef logic [IDX_BITS-1:0]   idx_type;
   typedef logic [CNT_BITS-1:0]   cnt_type;
   typedef logic [SUM_BITS-1:0]   sum_type;
   typedef logic [ADD_BITS-1:0]   add_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_SWAP,
      ST_EMIT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;   // store an accepted burst
      logic rd;     // issue a scan read
      logic swap;   // move head entry into the minimum's slot
      logic emit;   // write minimum to head slot and load the result register
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_last;   // scan index is at the last stored job
      logic final_pass;  // current pass is the last one of the batch
      logic out_free;    // result register can take a new beat
   } dp_sts_type;

endpackage

// ----- sv/sjf_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine: load, selection-sort scan, swap and emit sequencing.
module sjf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_last,
   output logic                req_ready,
   input  sjf_pkg::dp_sts_type sts,
   output sjf_pkg::dp_cmd_type cmd
);
   import sjf_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.rd = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         // last read data is compared in this cycle
         ST_DRAIN: begin
            state_in = ST_SWAP;
         end
         ST_SWAP: begin
            cmd.swap = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = sts.final_pass ? ST_IDLE : ST_SCAN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- sv/sjf_dp.sv -----
`timescale 1ns / 1ps
// Datapath: burst store, minimum search, running sums and result register.
module sjf_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [sjf_pkg::IN_BURST_BITS-1:0]   req_burst,
   input  sjf_pkg::dp_cmd_type                 cmd,
   output sjf_pkg::dp_sts_type                 sts,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [sjf_pkg::POS_BITS-1:0]        rsp_position,
   output logic [sjf_pkg::IN_BURST_BITS-1:0]   rsp_sorted_burst,
   output logic [sjf_pkg::SUM_BITS-1:0]        rsp_waiting_time,
   output logic [sjf_pkg::SUM_BITS-1:0]        rsp_turnaround_time,
   output logic                                rsp_overflowed,
   output logic                                rsp_final_res
);
   import sjf_pkg::*;

   burst_type mem [MAX_JOBS];

   // control state
   cnt_type cnt_ff, cnt_in;
   logic    ovf_ff, ovf_in;
   idx_type pos_ff, pos_in;
   idx_type scan_ff, scan_in;
   sum_type sum_ff, sum_in;
   logic    rd_vld_ff, rd_vld_in;
   logic    rsp_valid_ff, rsp_valid_in;

   // payload
   burst_type rd_data_ff;
   idx_type   rd_idx_ff;
   burst_type min_ff;
   idx_type   min_idx_ff;
   burst_type head_ff;
   logic [POS_BITS-1:0]      pos_out_ff;
   logic [IN_BURST_BITS-1:0] burst_out_ff;
   sum_type                  wait_out_ff;
   sum_type                  turn_out_ff;
   logic                     ovf_out_ff;
   logic                     final_out_ff;

   logic      full;
   idx_type   last_idx;
   logic      wr_en;
   idx_type   wr_addr;
   burst_type wr_data;
   add_type   sum_ext;
   sum_type   turn_sat;
   logic      rd_first;

   assign full     = (cnt_ff == CNT_BITS'(MAX_JOBS));
   assign last_idx = idx_type'(cnt_ff - CNT_BITS'(1));
   assign sum_ext  = ADD_BITS'(sum_ff) + ADD_BITS'(min_ff);
   assign turn_sat = (sum_ext[ADD_BITS-1:SUM_BITS] != '0) ? '1 : sum_ext[SUM_BITS-1:0];
   assign rd_first = (rd_idx_ff == pos_ff);

   assign sts.scan_last  = (scan_ff == last_idx);
   assign sts.final_pass = (pos_ff == last_idx);
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;

   // single write port; the three writers never coincide
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pos_ff;
      wr_data = min_ff;
      priority if (cmd.load && !full) begin
         wr_en   = 1'b1;
         wr_addr = idx_type'(cnt_ff);
         wr_data = BURST_BITS'(req_burst);
      end else if (cmd.swap) begin
         wr_en   = 1'b1;
         wr_addr = min_idx_ff;
         wr_data = head_ff;
      end else if (cmd.emit) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[scan_ff];
      rd_idx_ff  <= scan_ff;
   end

   always_comb begin
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      pos_in       = pos_ff;
      scan_in      = scan_ff;
      sum_in       = sum_ff;
      rd_vld_in    = cmd.rd;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.load) begin
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + CNT_BITS'(1);
         end
      end
      if (cmd.rd) begin
         scan_in = scan_ff + IDX_BITS'(1);
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         if (sts.final_pass) begin
            cnt_in  = '0;
            ovf_in  = 1'b0;
            pos_in  = '0;
            scan_in = '0;
            sum_in  = '0;
         end else begin
            pos_in  = pos_ff + IDX_BITS'(1);
            scan_in = pos_ff + IDX_BITS'(1);
            sum_in  = turn_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         pos_ff       <= '0;
         scan_ff      <= '0;
         sum_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         pos_ff       <= pos_in;
         scan_ff      <= scan_in;
         sum_ff       <= sum_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // running minimum; the first read of a pass is the head entry
   always_ff @(posedge clock) begin
      if (rd_vld_ff) begin
         if (rd_first || (rd_data_ff < min_ff)) begin
            min_ff     <= rd_data_ff;
            min_idx_ff <= rd_idx_ff;
         end
         if (rd_first) begin
            head_ff <= rd_data_ff;
         end
      end
      if (cmd.emit) begin
         pos_out_ff   <= POS_BITS'(pos_ff);
         burst_out_ff <= IN_BURST_BITS'(min_ff);
         wait_out_ff  <= sum_ff;
         turn_out_ff  <= turn_sat;
         ovf_out_ff   <= ovf_ff;
         final_out_ff <= sts.final_pass;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_position        = pos_out_ff;
   assign rsp_sorted_burst    = burst_out_ff;
   assign rsp_waiting_time    = wait_out_ff;
   assign rsp_turnaround_time = turn_out_ff;
   assign rsp_overflowed      = ovf_out_ff;
   assign rsp_final_res       = final_out_ff;

endmodule

// ----- sv/sjf_wait_turnaround_calc.sv -----
`timescale 1ns / 1ps
// Top level of the shortest-job-first waiting and turnaround time calculator.
//
// req_ channel: one job burst per beat; req_last closes the batch. Up to
// MAX_JOBS bursts are kept; further ones are dropped and the batch is flagged.
// Loading accepts one beat per cycle; req_ready is high only while the block
// is collecting a batch.
// After the last beat the store is selection-sorted in place through one
// registered read port. Pass i scans the n-i unsorted entries, one read a
// cycle, then goes through three steps (drain, swap, emit) and gives one
// rsp_ beat for the minimum that it found.
// rsp_ channel: one beat per job in ascending burst order with position,
// waiting and turnaround times; rsp_final_res marks the batch's last beat.
// The result register holds a beat until it is taken; a stalled receiver
// holds the sort at the emit step. New bursts are accepted while the final
// beat of the previous batch still waits.
// Reset (synchronous) empties the batch and clears the overflow flag and the
// result valid; store contents are left as they are.
module sjf_wait_turnaround_calc (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [sjf_pkg::IN_BURST_BITS-1:0] req_burst,
   input  logic                              req_last,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [sjf_pkg::POS_BITS-1:0]      rsp_position,
   output logic [sjf_pkg::IN_BURST_BITS-1:0] rsp_sorted_burst,
   output logic [sjf_pkg::SUM_BITS-1:0]      rsp_waiting_time,
   output logic [sjf_pkg::SUM_BITS-1:0]      rsp_turnaround_time,
   output logic                              rsp_overflowed,
   output logic                              rsp_final_res
);
   import sjf_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   sjf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sjf_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .req_burst           (req_burst),
      .cmd                 (cmd),
      .sts                 (sts),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_position        (rsp_position),
      .rsp_sorted_burst    (rsp_sorted_burst),
      .rsp_waiting_time    (rsp_waiting_time),
      .rsp_turnaround_time (rsp_turnaround_time),
      .rsp_overflowed      (rsp_overflowed),
      .rsp_final_res       (rsp_final_res)
   );

endmodule

// ----- sv/sjf_chk.sv -----
`timescale 1ns / 1ps
// Port-level checker for the SJF calculator, bound to the top level.
module sjf_chk (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [sjf_pkg::POS_BITS-1:0]      rsp_position,
   input logic [sjf_pkg::IN_BURST_BITS-1:0] rsp_sorted_burst,
   input logic [sjf_pkg::SUM_BITS-1:0]      rsp_waiting_time,
   input logic [sjf_pkg::SUM_BITS-1:0]      rsp_turnaround_time,
   input logic                              rsp_overflowed,
   input logic                              rsp_final_res
);
   import sjf_pkg::*;

   // previous beat of the batch being delivered
   logic                     prev_vld_ff;
   sum_type                  prev_turn_ff;
   logic [IN_BURST_BITS-1:0] prev_burst_ff;
   logic [POS_BITS-1:0]      prev_pos_ff;
   logic                     prev_ovf_ff;
   logic                     rsp_beat;

   assign rsp_beat = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_vld_ff <= 1'b0;
      end else if (rsp_beat) begin
         prev_vld_ff <= !rsp_final_res;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_beat) begin
         prev_turn_ff  <= rsp_turnaround_time;
         prev_burst_ff <= rsp_sorted_burst;
         prev_pos_ff   <= rsp_position;
         prev_ovf_ff   <= rsp_overflowed;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_waiting_time)
         && $stable(rsp_sorted_burst) && $stable(rsp_final_res))
      else $error("result beat changed while stalled");

   a_first_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !prev_vld_ff |-> rsp_waiting_time == '0 && rsp_position == '0)
      else $error("first beat of batch has nonzero waiting time or position");

   a_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && prev_vld_ff |-> rsp_waiting_time == prev_turn_ff
         && rsp_position == prev_pos_ff + 4'd1 && rsp_overflowed == prev_ovf_ff)
      else $error("waiting time does not follow previous turnaround");

   a_ascending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && prev_vld_ff |-> rsp_sorted_burst >= prev_burst_ff)
      else $error("bursts not in ascending order");

   a_no_load_mid_batch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_final_res |-> !req_ready)
      else $error("input taken while a batch is being delivered");

endmodule

bind sjf_wait_turnaround_calc sjf_chk u_sjf_chk (.*);

// ----- tb/tb_sjf_wait_turnaround_calc.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the shortest-job-first waiting and turnaround calculator.
module tb_sjf_wait_turnaround_calc;
   import sjf_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 60;
   localparam int HOLD_CYCLES  = 600;
   localparam int RANDOM_ITEMS = 250;
   localparam int NUM_PHASES   = 4;
   localparam longint SUM_CEIL = (64'd1 << SUM_BITS) - 1;

   typedef struct packed {
      logic [POS_BITS-1:0]      position;
      logic [IN_BURST_BITS-1:0] burst;
      logic [SUM_BITS-1:0]      waiting;
      logic [SUM_BITS-1:0]      turnaround;
      logic                     overflowed;
      logic                     final_res;
   } sched_beat_type;

   // Keeps the bursts of the open batch in ascending order and, when the batch
   // closes, turns them into the expected schedule.
   class sjf_order_scoreboard;
      logic [BURST_BITS-1:0] batch_sorted[$];
      logic                  batch_dropped;
      sched_beat_type        expected_beats[$];
      int                    fail_count;
      int                    reported;

      function new();
         batch_dropped = 1'b0;
         fail_count    = 0;
         reported      = 0;
      endfunction

      function longint clip_sum(input longint v);
         return (v > SUM_CEIL) ? SUM_CEIL : v;
      endfunction

      function void note_burst(input logic [IN_BURST_BITS-1:0] burst, input logic last);
         logic [BURST_BITS-1:0] kept;
         int                    slot;
         longint                wait_sum;
         sched_beat_type        beat;
         kept = burst[BURST_BITS-1:0];
         if (batch_sorted.size() < MAX_JOBS) begin
            slot = 0;
            while (slot < batch_sorted.size() && batch_sorted[slot] <= kept)
               slot++;
            batch_sorted.insert(slot, kept);
         end else begin
            batch_dropped = 1'b1;
         end
         if (last) begin
            wait_sum = 0;
            for (int k = 0; k < batch_sorted.size(); k++) begin
               beat.position   = k[POS_BITS-1:0];
               beat.burst      = IN_BURST_BITS'(batch_sorted[k]);
               beat.waiting    = SUM_BITS'(wait_sum);
               beat.turnaround = SUM_BITS'(clip_sum(wait_sum + batch_sorted[k]));
               beat.overflowed = batch_dropped;
               beat.final_res  = (k == batch_sorted.size() - 1);
               expected_beats.push_back(beat);
               wait_sum = clip_sum(wait_sum + batch_sorted[k]);
            end
            batch_sorted.delete();
            batch_dropped = 1'b0;
         end
      endfunction

      function void flag_error(input string what, input sched_beat_type exp_b,
                               input sched_beat_type got_b);
         fail_count++;
         if (reported < 10) begin
            reported++;
            $display("[%0t] %s: exp pos=%0d burst=%0d wait=%0d tat=%0d ovf=%0b fin=%0b",
                     $time, what, exp_b.position, exp_b.burst, exp_b.waiting,
                     exp_b.turnaround, exp_b.overflowed, exp_b.final_res);
            $display("[%0t] %s: got pos=%0d burst=%0d wait=%0d tat=%0d ovf=%0b fin=%0b",
                     $time, what, got_b.position, got_b.burst, got_b.waiting,
                     got_b.turnaround, got_b.overflowed, got_b.final_res);
         end
      endfunction

      function void check_beat(input sched_beat_type got_b);
         sched_beat_type exp_b;
         if (expected_beats.size() == 0) begin
            flag_error("unexpected beat", '0, got_b);
         end else begin
            exp_b = expected_beats.pop_front();
            if (got_b.position   !== exp_b.position   ||
                got_b.burst      !== exp_b.burst      ||
                got_b.waiting    !== exp_b.waiting    ||
                got_b.turnaround !== exp_b.turnaround ||
                got_b.overflowed !== exp_b.overflowed ||
                got_b.final_res  !== exp_b.final_res)
               flag_error("mismatch", exp_b, got_b);
         end
      endfunction

      function int pending();
         return expected_beats.size();
      endfunction

      function void close_out();
         if (expected_beats.size() != 0) begin
            fail_count++;
            $display("%0d expected beats never arrived", expected_beats.size());
         end
      endfunction
   endclass

   logic                       clock;
   logic                       reset     = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [IN_BURST_BITS-1:0]   req_burst = '0;
   logic                       req_last  = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [POS_BITS-1:0]        rsp_position;
   logic [IN_BURST_BITS-1:0]   rsp_sorted_burst;
   logic [SUM_BITS-1:0]        rsp_waiting_time;
   logic [SUM_BITS-1:0]        rsp_turnaround_time;
   logic                       rsp_overflowed;
   logic                       rsp_final_res;

   sjf_order_scoreboard schedule_board = new();
   int  send_idle_pct  = 0;
   int  recv_stall_pct = 0;
   int  hold_request   = 0;
   int  hold_left      = 0;
   int  cycle_count    = 0;
   int  bursts_sent    = 0;

   sjf_wait_turnaround_calc dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_burst           (req_burst),
      .req_last            (req_last),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_position        (rsp_position),
      .rsp_sorted_burst    (rsp_sorted_burst),
      .rsp_waiting_time    (rsp_waiting_time),
      .rsp_turnaround_time (rsp_turnaround_time),
      .rsp_overflowed      (rsp_overflowed),
      .rsp_final_res       (rsp_final_res)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT)
         @(posedge clock);
      $display("DONE: errors detected");
      $finish;
   end

   // Result side: check each accepted beat, then pick next cycle's ready.
   always @(posedge clock) begin
      sched_beat_type got_b;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got_b.position   = rsp_position;
            got_b.burst      = rsp_sorted_burst;
            got_b.waiting    = rsp_waiting_time;
            got_b.turnaround = rsp_turnaround_time;
            got_b.overflowed = rsp_overflowed;
            got_b.final_res  = rsp_final_res;
            schedule_board.check_beat(got_b);
         end
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // valid is left high after a beat; the next call either keeps it or drops it
   task automatic send_burst(input logic [IN_BURST_BITS-1:0] burst, input logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_burst <= burst;
      req_last  <= last;
      do
         @(posedge clock);
      while (!req_ready);
      schedule_board.note_burst(burst, last);
      bursts_sent++;
   endtask

   function automatic logic [IN_BURST_BITS-1:0] pick_burst();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 6)
         return IN_BURST_BITS'($urandom_range(0, 65535));
      else if (sel < 8)
         return IN_BURST_BITS'($urandom_range(0, 15));   // many ties
      else if (sel == 8)
         return $urandom_range(0, 1) ? '1 : '0;
      else
         return IN_BURST_BITS'($urandom_range(65500, 65535));
   endfunction

   task automatic send_random_batch();
      int jobs;
      if ($urandom_range(0, 99) < 10)
         jobs = $urandom_range(MAX_JOBS + 1, MAX_JOBS + 4);
      else if ($urandom_range(0, 99) < 15)
         jobs = MAX_JOBS;
      else
         jobs = $urandom_range(1, MAX_JOBS);
      for (int j = 0; j < jobs; j++)
         send_burst(pick_burst(), j == jobs - 1);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single-job batches at both ends of the burst range
      send_burst('0, 1'b1);
      send_burst('1, 1'b1);
      // unsorted batch with a tie
      send_burst(16'd9, 1'b0);
      send_burst(16'd2, 1'b0);
      send_burst(16'd9, 1'b1);
      // full store of maximum bursts, then a last beat that gets dropped
      for (int j = 0; j < MAX_JOBS; j++)
         send_burst('1, 1'b0);
      send_burst(16'h1234, 1'b1);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
               hold_request   = HOLD_CYCLES;   // receiver blocked, sender keeps offering
            end
            1: begin
               send_idle_pct  = 85;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 85;
            end
            default: begin
               send_idle_pct  = 31;
               recv_stall_pct = 31;
            end
         endcase
         while (bursts_sent < 22 + (phase + 1) * RANDOM_ITEMS / NUM_PHASES)
            send_random_batch();
      end
      req_valid <= 1'b0;

      while (schedule_board.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      schedule_board.close_out();
      if (schedule_board.fail_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- sim.f -----
sv/sjf_pkg.sv
sv/sjf_ctrl.sv
sv/sjf_dp.sv
sv/sjf_wait_turnaround_calc.sv
sv/sjf_chk.sv
tb/tb_sjf_wait_turnaround_calc.sv
